// ===== sv/pine_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pine_pkg
// Shared types, codes and helpers of the packed intensity nibble encoder.
// ----------------------------------------------------------------------------
package pine_pkg;

	localparam int TAB_DEPTH = 16;
	localparam int NIB_DEPTH = 14;
	localparam logic [7:0] HEADER_BYTE = 8'hf1;
	localparam logic [6:0] PCT_MAX = 7'd100;
	localparam logic [12:0] DIV_RECIP = 13'd5243;

	typedef logic [1:0] op_t;
	localparam op_t OP_WRITE = 2'd0;
	localparam op_t OP_BUILD = 2'd1;
	localparam op_t OP_MOTOR = 2'd2;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_RAMP_NUM = 2'd0;
	localparam reg_idx_t REG_RAMP_DEN = 2'd1;
	localparam reg_idx_t REG_RAMP_ICPT = 2'd2;

	typedef struct packed {
		logic load;
		logic tab_wr;
		logic build_init;
		logic acc_step;
		logic div_load;
		logic div_step;
		logic build_wr;
		logic duty_calc;
		logic srch_step;
		logic place;
		logic ovf_set;
		logic emit;
		logic ocnt_inc;
		logic frame_clr;
	} cmd_t;

	typedef struct packed {
		logic pos_full;
		logic div_done;
		logic build_done;
		logic srch_done;
		logic out_end;
	} status_t;

	// percent to duty: floor(min(pct,100) * 255 / 100) by reciprocal multiply
	function automatic logic [7:0] duty_of(input logic [6:0] pct);
		logic [6:0] pc;
		logic [14:0] x;
		logic [27:0] y;
		pc = (pct > PCT_MAX) ? PCT_MAX : pct;
		x = {pc, 8'd0} - {8'd0, pc};
		y = {13'd0, x} * {15'd0, DIV_RECIP};
		return y[26:19];
	endfunction

endpackage
`default_nettype wire

// ===== sv/pine_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pine channel interfaces
// Item, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pine_item_if;
	logic valid;
	logic ready;
	logic [1:0] op;
	logic [3:0] entry_index;
	logic [7:0] entry_duty;
	logic [6:0] intensity;
	logic last_motor;
	modport source (output valid, op, entry_index, entry_duty, intensity, last_motor,
		input ready);
	modport sink (input valid, op, entry_index, entry_duty, intensity, last_motor,
		output ready);
endinterface

interface pine_result_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic [2:0] byte_index;
	logic rejected;
	logic last;
	modport source (output valid, out_byte, byte_index, rejected, last, input ready);
	modport sink (input valid, out_byte, byte_index, rejected, last, output ready);
endinterface

interface pine_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [12:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/packed_intensity_nibble_encoder_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// packed_intensity_nibble_encoder_unit
// Packs motor intensities as nearest 4-bit duty-table codes into a header
// byte plus seven data bytes.
// ----------------------------------------------------------------------------
// One item is in flight at a time. A motor intensity is matched by comparing
// one duty-table entry per cycle over all 16 entries, and a table build
// computes 15 entries, each through a 16-step bit-serial divider. On the last
// motor of a frame the block then presents 8 message bytes, or one reject
// result, and takes no new item until they are all taken. Configuration
// writes are taken every cycle.
module packed_intensity_nibble_encoder_unit #(
	parameter int MAX_MOTORS = 14
) (
	input wire logic       clk,
	input wire logic       arst_n,
	pine_item_if.sink      item,
	pine_result_if.source  result,
	pine_cfg_if.sink       cfg
);
	import pine_pkg::*;

	cmd_t cmd;
	status_t st;

	assign cfg.ready = 1'b1;
	assign result.valid = cmd.emit;

	pine_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_op      (item.op),
		.item_last    (item.last_motor),
		.item_ready   (item.ready),
		.result_ready (result.ready),
		.st           (st),
		.cmd          (cmd)
	);

	pine_dp #(
		.MAX_MOTORS (MAX_MOTORS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.cfg_we      (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.entry_index (item.entry_index),
		.entry_duty  (item.entry_duty),
		.intensity   (item.intensity),
		.out_byte    (result.out_byte),
		.byte_index  (result.byte_index),
		.rejected    (result.rejected),
		.last        (result.last)
	);

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(result.valid && item.ready))
		else $error("item request taken while message pending");

	a_reject_form: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.rejected) |-> (result.last && result.byte_index == 3'd0
			&& result.out_byte == 8'd0))
		else $error("reject result malformed");

	a_end_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.ready && result.last) |=> !result.valid)
		else $error("result request after end of frame");

	a_header_first: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.rejected && result.byte_index == 3'd0)
			|-> (result.out_byte == HEADER_BYTE))
		else $error("first message byte is not the header");
`endif

endmodule
`default_nettype wire

// ===== sv/pine_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pine_dp
// Datapath: duty table, ramp builder with serial divider, nearest-code scan,
// nibble store and message byte selection.
// ----------------------------------------------------------------------------
module pine_dp #(
	parameter int MAX_MOTORS = 14
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pine_pkg::cmd_t     cmd,
	output pine_pkg::status_t       st,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [12:0]        cfg_data,
	input  wire logic [3:0]         entry_index,
	input  wire logic [7:0]         entry_duty,
	input  wire logic [6:0]         intensity,
	output logic [7:0]              out_byte,
	output logic [2:0]              byte_index,
	output logic                    rejected,
	output logic                    last
);
	import pine_pkg::*;

	logic [7:0] tab_q [TAB_DEPTH];
	logic [3:0] nib_q [NIB_DEPTH];
	logic signed [12:0] num_q;
	logic [11:0] den_q;
	logic signed [8:0] icpt_q;
	logic [3:0] idx_q;
	logic [7:0] edu_q;
	logic [6:0] pct_q;
	logic [3:0] pos_q;
	logic ovf_q;
	logic [2:0] ocnt_q;
	logic [7:0] duty_q;
	logic [3:0] sidx_q;
	logic [3:0] best_q;
	logic [7:0] bestd_q;
	logic [3:0] bidx_q;
	logic signed [16:0] acc_q;
	logic neg_q;
	logic [15:0] dvd_q;
	logic [11:0] rem_q;
	logic [3:0] dcnt_q;

	logic [11:0] den_eff;
	logic [11:0] half;
	logic signed [16:0] n_sum;
	logic [15:0] n_mag;
	logic [12:0] t_rem;
	logic [12:0] t_sub;
	logic t_ge;
	logic signed [16:0] q_s;
	logic signed [17:0] v_s;
	logic [7:0] v_clamp;
	logic [8:0] diff;
	logic [7:0] ad;
	logic better;
	logic [2:0] obyte;
	logic [7:0] data_byte;

	assign den_eff = (den_q == 12'd0) ? 12'd1 : den_q;
	assign half = den_eff >> 1;
	assign n_sum = acc_q + $signed({5'd0, half});
	assign n_mag = n_sum[16] ? 16'(-n_sum) : n_sum[15:0];
	assign t_rem = {rem_q, dvd_q[15]};
	assign t_ge = t_rem >= {1'b0, den_eff};
	assign t_sub = t_rem - {1'b0, den_eff};
	assign q_s = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
	assign v_s = {q_s[16], q_s} + {{9{icpt_q[8]}}, icpt_q};

	always_comb begin
		if (v_s[17]) begin
			v_clamp = 8'd0;
		end else if (|v_s[16:8]) begin
			v_clamp = 8'hff;
		end else begin
			v_clamp = v_s[7:0];
		end
	end

	assign diff = {1'b0, tab_q[sidx_q]} - {1'b0, duty_q};
	assign ad = diff[8] ? 8'(-diff) : diff[7:0];
	assign better = (sidx_q == 4'd0) || (ad < bestd_q);

	assign obyte = ocnt_q - 3'd1;
	assign data_byte = {nib_q[{obyte, 1'b0}], nib_q[{obyte, 1'b1}]};

	assign out_byte = ovf_q ? 8'd0 : ((ocnt_q == 3'd0) ? HEADER_BYTE : data_byte);
	assign byte_index = ovf_q ? 3'd0 : ocnt_q;
	assign rejected = ovf_q;
	assign last = ovf_q || (ocnt_q == 3'd7);

	assign st.pos_full = pos_q >= 4'(MAX_MOTORS);
	assign st.div_done = dcnt_q == 4'd15;
	assign st.build_done = bidx_q == 4'd15;
	assign st.srch_done = sidx_q == 4'd15;
	assign st.out_end = ovf_q || (ocnt_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= 13'sd127;
			den_q <= 12'd15;
			icpt_q <= 9'sd128;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RAMP_NUM: num_q <= cfg_data;
				REG_RAMP_DEN: den_q <= cfg_data[11:0];
				REG_RAMP_ICPT: icpt_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAB_DEPTH; i++) begin
				tab_q[i] <= 8'd0;
			end
		end else if (cmd.build_init) begin
			tab_q[0] <= 8'd0;
		end else if (cmd.tab_wr) begin
			tab_q[idx_q] <= edu_q;
		end else if (cmd.build_wr) begin
			tab_q[bidx_q] <= v_clamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NIB_DEPTH; i++) begin
				nib_q[i] <= 4'd0;
			end
			pos_q <= 4'd0;
			ovf_q <= 1'b0;
			ocnt_q <= 3'd0;
		end else if (cmd.frame_clr) begin
			for (int i = 0; i < NIB_DEPTH; i++) begin
				nib_q[i] <= 4'd0;
			end
			pos_q <= 4'd0;
			ovf_q <= 1'b0;
			ocnt_q <= 3'd0;
		end else begin
			if (cmd.place) begin
				nib_q[pos_q] <= best_q;
				pos_q <= pos_q + 4'd1;
			end
			if (cmd.ovf_set) begin
				ovf_q <= 1'b1;
			end
			if (cmd.ocnt_inc) begin
				ocnt_q <= ocnt_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q <= entry_index;
			edu_q <= entry_duty;
			pct_q <= intensity;
		end
		if (cmd.duty_calc) begin
			duty_q <= duty_of(pct_q);
			sidx_q <= 4'd0;
		end else if (cmd.srch_step) begin
			if (better) begin
				best_q <= sidx_q;
				bestd_q <= ad;
			end
			sidx_q <= sidx_q + 4'd1;
		end
		if (cmd.build_init) begin
			acc_q <= 17'sd0;
			bidx_q <= 4'd1;
		end else if (cmd.acc_step) begin
			acc_q <= acc_q + {{4{num_q[12]}}, num_q};
		end else if (cmd.build_wr) begin
			bidx_q <= bidx_q + 4'd1;
		end
		if (cmd.div_load) begin
			neg_q <= n_sum[16];
			dvd_q <= n_mag;
			rem_q <= 12'd0;
			dcnt_q <= 4'd0;
		end else if (cmd.div_step) begin
			rem_q <= t_ge ? t_sub[11:0] : t_rem[11:0];
			dvd_q <= {dvd_q[14:0], t_ge};
			dcnt_q <= dcnt_q + 4'd1;
		end
	end

endmodule
`default_nettype wire

// ===== sv/pine_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pine_ctrl
// Controller: sequences table writes, ramp build, nearest-code scan and
// message emission.
// ----------------------------------------------------------------------------
module pine_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_valid,
	input  wire logic [1:0]    item_op,
	input  wire logic          item_last,
	output logic               item_ready,
	input  wire logic          result_ready,
	input  wire pine_pkg::status_t st,
	output pine_pkg::cmd_t     cmd
);
	import pine_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_TWR, S_OVF, S_DUTY, S_SRCH, S_PLACE,
		S_BINIT, S_BACC, S_BLOAD, S_BDIV, S_BWR, S_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic last_q;

	assign item_ready = state_q == S_IDLE;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					case (item_op)
						OP_WRITE: state_d = S_TWR;
						OP_BUILD: state_d = S_BINIT;
						OP_MOTOR: state_d = st.pos_full ? S_OVF : S_DUTY;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_TWR: begin
				cmd.tab_wr = 1'b1;
				state_d = S_IDLE;
			end
			S_OVF: begin
				cmd.ovf_set = 1'b1;
				state_d = last_q ? S_EMIT : S_IDLE;
			end
			S_DUTY: begin
				cmd.duty_calc = 1'b1;
				state_d = S_SRCH;
			end
			S_SRCH: begin
				cmd.srch_step = 1'b1;
				if (st.srch_done) begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				cmd.place = 1'b1;
				state_d = last_q ? S_EMIT : S_IDLE;
			end
			S_BINIT: begin
				cmd.build_init = 1'b1;
				state_d = S_BACC;
			end
			S_BACC: begin
				cmd.acc_step = 1'b1;
				state_d = S_BLOAD;
			end
			S_BLOAD: begin
				cmd.div_load = 1'b1;
				state_d = S_BDIV;
			end
			S_BDIV: begin
				cmd.div_step = 1'b1;
				if (st.div_done) begin
					state_d = S_BWR;
				end
			end
			S_BWR: begin
				cmd.build_wr = 1'b1;
				state_d = st.build_done ? S_IDLE : S_BACC;
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				if (result_ready) begin
					if (st.out_end) begin
						cmd.frame_clr = 1'b1;
						state_d = S_IDLE;
					end else begin
						cmd.ocnt_inc = 1'b1;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				last_q <= item_last;
			end
		end
	end

endmodule
`default_nettype wire

// ===== test/pine_frame_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pine_frame_checker
// Follows the register writes and requests taken by the nibble encoder, keeps
// its own duty table, ramp settings and frame store, predicts every message
// byte or reject, and compares the result channel against the oldest one.
// ----------------------------------------------------------------------------
module pine_frame_checker #(
	parameter int MAX_MOTORS = 14
) (
	input  logic   clk,
	input  logic   arst_n,
	pine_item_if   item,
	pine_result_if result,
	pine_cfg_if    cfg,
	output int     mismatches,
	output int     bytes_owed,
	output int     bytes_seen
);
	import pine_pkg::*;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] byte_index;
		logic       rejected;
		logic       last;
	} msg_byte_t;

	logic [7:0]         duty_tab [TAB_DEPTH];
	logic [7:0]         msg_store [7];
	int                 motor_cnt;
	logic               overflowed;
	logic signed [12:0] ramp_num;
	logic [11:0]        ramp_den;
	logic signed [8:0]  ramp_icpt;
	msg_byte_t          owed_bytes [$];
	msg_byte_t          want;
	msg_byte_t          owed;
	logic [3:0]         code;
	int                 duty;
	int                 gap;
	int                 best_gap;
	int                 den;
	int                 ramp_val;

	task automatic report(input string what, input logic [7:0] got, input logic [7:0] exp_val);
		$display("%0t ns: %s mismatch: got %h, want %h", $time, what, got, exp_val);
		mismatches++;
	endtask

	function automatic void clear_frame();
		foreach (msg_store[k]) begin
			msg_store[k] = '0;
		end
		motor_cnt = 0;
		overflowed = 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (duty_tab[k]) begin
				duty_tab[k] = '0;
			end
			clear_frame();
			ramp_num = 13'sd127;
			ramp_den = 12'd15;
			ramp_icpt = 9'sd128;
			owed_bytes.delete();
			mismatches = 0;
			bytes_seen = 0;
		end else begin
			if (cfg.valid === 1'b1 && cfg.ready === 1'b1) begin
				case (cfg.index)
					REG_RAMP_NUM: ramp_num = cfg.data;
					REG_RAMP_DEN: ramp_den = cfg.data[11:0];
					REG_RAMP_ICPT: ramp_icpt = cfg.data[8:0];
					default: ;
				endcase
			end

			if (result.valid === 1'b1 && result.ready === 1'b1) begin
				bytes_seen++;
				if (owed_bytes.size() == 0) begin
					report("unexpected result byte", result.out_byte, 'x);
				end else begin
					want = owed_bytes.pop_front();
					if (result.out_byte !== want.out_byte) begin
						report("out_byte", result.out_byte, want.out_byte);
					end
					if (result.byte_index !== want.byte_index) begin
						report("byte_index", result.byte_index, want.byte_index);
					end
					if (result.rejected !== want.rejected) begin
						report("rejected", result.rejected, want.rejected);
					end
					if (result.last !== want.last) begin
						report("last", result.last, want.last);
					end
				end
			end

			if (item.valid === 1'b1 && item.ready === 1'b1) begin
				case (item.op)
					OP_WRITE: begin
						duty_tab[item.entry_index] = item.entry_duty;
					end
					OP_BUILD: begin
						den = (ramp_den == '0) ? 1 : int'(ramp_den);
						duty_tab[0] = '0;
						for (int i = 1; i < TAB_DEPTH; i++) begin
							ramp_val = (i * int'(ramp_num) + den / 2) / den + int'(ramp_icpt);
							if (ramp_val < 0) begin
								ramp_val = 0;
							end
							if (ramp_val > 255) begin
								ramp_val = 255;
							end
							duty_tab[i] = 8'(ramp_val);
						end
					end
					OP_MOTOR: begin
						if (motor_cnt < MAX_MOTORS) begin
							duty = (item.intensity > PCT_MAX) ? PCT_MAX : item.intensity;
							duty = duty * 255 / 100;
							code = '0;
							best_gap = 256;
							// strict compare keeps the lowest code on a tie
							for (int i = 0; i < TAB_DEPTH; i++) begin
								gap = int'(duty_tab[i]) - duty;
								if (gap < 0) begin
									gap = -gap;
								end
								if (gap < best_gap) begin
									best_gap = gap;
									code = 4'(i);
								end
							end
							if (motor_cnt % 2 == 0) begin
								msg_store[motor_cnt / 2][7:4] = code;
							end else begin
								msg_store[motor_cnt / 2][3:0] = code;
							end
							motor_cnt++;
						end else begin
							overflowed = 1'b1;
						end
						if (item.last_motor) begin
							if (overflowed) begin
								owed = '{out_byte: '0, byte_index: '0, rejected: 1'b1, last: 1'b1};
								owed_bytes.push_back(owed);
							end else begin
								for (int k = 0; k < 8; k++) begin
									if (k == 0) begin
										owed.out_byte = HEADER_BYTE;
									end else begin
										owed.out_byte = msg_store[k - 1];
									end
									owed.byte_index = 3'(k);
									owed.rejected = 1'b0;
									owed.last = (k == 7);
									owed_bytes.push_back(owed);
								end
							end
							clear_frame();
						end
					end
					default: ;
				endcase
			end
		end
		bytes_owed = owed_bytes.size();
	end

endmodule

// ===== test/packed_intensity_nibble_encoder_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packed_intensity_nibble_encoder_unit_tb
// Resets the encoder, runs a short directed set of requests, then phases of
// random table writes, table builds and motor frames under several ramp
// settings, with random idling on both channels and one long result stall.
// ----------------------------------------------------------------------------
module packed_intensity_nibble_encoder_unit_tb;
	import pine_pkg::*;

	localparam int MAX_MOTORS = 14;
	localparam int CLK_PERIOD = 10;
	localparam int RESET_CYCLES = 6;
	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int SETTLE_CYCLES = 320;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASES = 7;
	localparam int PHASE_REQUESTS = 40;
	localparam op_t OP_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	int   mismatches;
	int   bytes_owed;
	int   bytes_seen;
	int   cycle_count;
	bit   hold_off;
	int   sender_calm;
	int   requests;
	int   frames;
	int   over_frames;
	int   builds;
	int   entry_writes;
	int   cfg_writes;
	int   frame_len;

	pine_item_if   item ();
	pine_result_if result ();
	pine_cfg_if    cfg ();

	packed_intensity_nibble_encoder_unit #(
		.MAX_MOTORS(MAX_MOTORS)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.result(result),
		.cfg   (cfg)
	);

	pine_frame_checker #(
		.MAX_MOTORS(MAX_MOTORS)
	) frame_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.result    (result),
		.cfg       (cfg),
		.mismatches(mismatches),
		.bytes_owed(bytes_owed),
		.bytes_seen(bytes_seen)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int idle_len();
		if ($urandom_range(0, 9) == 0) begin
			return $urandom_range(20, 60);
		end
		return $urandom_range(1, 3);
	endfunction

	task automatic send_item(input op_t op, input logic [3:0] idx, input logic [7:0] duty,
			input logic [6:0] pct, input logic last_motor);
		int gap;
		gap = 0;
		if (sender_calm > 0) begin
			sender_calm--;
		end else if ($urandom_range(0, 99) < 4) begin
			sender_calm = $urandom_range(10, 30);
		end else if ($urandom_range(0, 99) >= 55) begin
			gap = idle_len();
		end
		if (gap > 0) begin
			item.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item.valid <= 1'b1;
		item.op <= op;
		item.entry_index <= idx;
		item.entry_duty <= duty;
		item.intensity <= pct;
		item.last_motor <= last_motor;
		do begin
			@(posedge clk);
		end while (item.ready !== 1'b1);
		@(negedge clk);
		case (op)
			OP_WRITE: entry_writes++;
			OP_BUILD: builds++;
			OP_MOTOR: begin
				frame_len++;
				if (last_motor) begin
					if (frame_len > MAX_MOTORS) begin
						over_frames++;
					end else begin
						frames++;
					end
					frame_len = 0;
				end
			end
			default: ;
		endcase
		if (op != OP_SPARE) begin
			requests++;
		end
	endtask

	task automatic drain();
		item.valid <= 1'b0;
		while (bytes_owed != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic load_ramp(input logic [12:0] num, input logic [12:0] den,
			input logic [12:0] icpt);
		reg_idx_t   regs [3];
		logic [12:0] vals [3];
		regs = '{REG_RAMP_NUM, REG_RAMP_DEN, REG_RAMP_ICPT};
		vals = '{num, den, icpt};
		for (int k = 0; k < 3; k++) begin
			cfg.valid <= 1'b1;
			cfg.index <= regs[k];
			cfg.data <= vals[k];
			do begin
				@(posedge clk);
			end while (cfg.ready !== 1'b1);
			@(negedge clk);
			cfg_writes++;
		end
		cfg.valid <= 1'b0;
	endtask

	// result side: random stalls, calm stretches, and one long hold on request
	initial begin
		int stall_left;
		int calm_left;
		stall_left = 0;
		calm_left = 0;
		result.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				result.ready <= 1'b0;
				for (int n = 1; n < HOLD_CYCLES; n++) begin
					@(negedge clk);
				end
				hold_off = 1'b0;
			end else if (stall_left > 0) begin
				result.ready <= 1'b0;
				stall_left--;
			end else begin
				result.ready <= 1'b1;
				if (calm_left > 0) begin
					calm_left--;
				end else if ($urandom_range(0, 99) < 4) begin
					calm_left = $urandom_range(20, 80);
				end else if ($urandom_range(0, 99) < 25) begin
					stall_left = idle_len();
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Cycle limit of %0d reached, %0d result bytes outstanding",
			LIMIT_CYCLES, bytes_owed);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int len;
		int kind;
		int n;
		logic [6:0] pct;
		arst_n = 1'b0;
		item.valid = 1'b0;
		item.op = OP_WRITE;
		item.entry_index = '0;
		item.entry_duty = '0;
		item.intensity = '0;
		item.last_motor = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_RAMP_NUM;
		cfg.data = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty table, then reset ramp, field extremes, spare op, saturation
		send_item(OP_MOTOR, 4'd0, 8'd0, 7'd0, 1'b0);
		send_item(OP_MOTOR, 4'd0, 8'd0, 7'd100, 1'b1);
		send_item(OP_BUILD, 4'd0, 8'd0, 7'd0, 1'b0);
		send_item(OP_WRITE, 4'd0, 8'd255, 7'd0, 1'b0);
		send_item(OP_WRITE, 4'd15, 8'd0, 7'd127, 1'b1);
		send_item(OP_SPARE, 4'd15, 8'd255, 7'd127, 1'b1);
		send_item(OP_MOTOR, 4'd0, 8'd0, 7'd0, 1'b0);
		send_item(OP_MOTOR, 4'd0, 8'd0, 7'd127, 1'b0);
		send_item(OP_MOTOR, 4'd0, 8'd0, 7'd64, 1'b1);
		// one motor too many
		for (int k = 0; k <= MAX_MOTORS; k++) begin
			send_item(OP_MOTOR, 4'($urandom), 8'($urandom), 7'($urandom_range(0, 100)),
				k == MAX_MOTORS);
		end

		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				0: load_ramp(13'h1000, 13'd1, 13'h1f00);
				1: load_ramp(13'h0fff, 13'h0fff, 13'h00ff);
				2: load_ramp(13'd127, 13'd0, 13'd0);
				3: load_ramp(13'h0fff, 13'd1, 13'h1f00);
				6: load_ramp(13'd127, 13'd15, 13'd128);
				default: load_ramp(13'($urandom), 13'($urandom), 13'($urandom));
			endcase
			send_item(OP_BUILD, 4'($urandom), 8'($urandom), 7'($urandom), 1'($urandom));
			if (p == 2) begin
				hold_off = 1'b1;
			end
			n = 1;
			while (n < PHASE_REQUESTS) begin
				kind = $urandom_range(0, 99);
				if (kind < 6) begin
					send_item(OP_BUILD, 4'($urandom), 8'($urandom), 7'($urandom), 1'($urandom));
					n++;
				end else if (kind < 20) begin
					send_item(OP_WRITE, 4'($urandom), 8'($urandom), 7'($urandom), 1'($urandom));
					n++;
				end else if (kind < 23) begin
					send_item(OP_SPARE, 4'($urandom), 8'($urandom), 7'($urandom), 1'($urandom));
				end else begin
					if ($urandom_range(0, 9) == 0) begin
						len = $urandom_range(MAX_MOTORS + 1, MAX_MOTORS + 6);
					end else begin
						len = $urandom_range(1, MAX_MOTORS);
					end
					for (int k = 0; k < len; k++) begin
						if (k < len - 1 && $urandom_range(0, 9) == 0) begin
							send_item(OP_WRITE, 4'($urandom), 8'($urandom), 7'($urandom),
								1'($urandom));
							n++;
						end
						if ($urandom_range(0, 6) == 0) begin
							pct = 7'($urandom_range(101, 127));
						end else begin
							pct = 7'($urandom_range(0, 100));
						end
						send_item(OP_MOTOR, 4'($urandom), 8'($urandom), pct, k == len - 1);
						n++;
					end
				end
			end
		end
		drain();

		$display("Ran %0d requests: %0d frames packed, %0d over-limit frames,",
			requests, frames, over_frames);
		$display("%0d table builds, %0d entry writes, %0d register writes, %0d bytes checked",
			builds, entry_writes, cfg_writes, bytes_seen);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/pine_pkg.sv
sv/pine_if.sv
sv/pine_dp.sv
sv/pine_ctrl.sv
sv/packed_intensity_nibble_encoder_unit.sv
test/pine_frame_checker.sv
test/packed_intensity_nibble_encoder_unit_tb.sv
